// File: src/indexed_sequence_list_defines.svh
// Assertion macros used by the indexed sequence list datapath.
`ifndef INDEXED_SEQUENCE_LIST_DEFINES_SVH
`define INDEXED_SEQUENCE_LIST_DEFINES_SVH

// Implication checked in the same cycle, disabled during reset.
`define ISL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define ISL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/isl_pkg.sv
// Package with opcodes, status codes and controller/datapath interface types.
package isl_pkg;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_POS   = 3'd1;
  localparam logic [2:0] OP_INS_END   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_POS   = 3'd4;
  localparam logic [2:0] OP_DEL_END   = 3'd5;
  localparam logic [2:0] OP_DUMP      = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INS_RANGE = 3'd2;
  localparam logic [2:0] ST_DEL_RANGE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] TGT_ZERO   = 2'd0;
  localparam logic [1:0] TGT_POS    = 2'd1;
  localparam logic [1:0] TGT_CNT    = 2'd2;
  localparam logic [1:0] TGT_CNT_M1 = 2'd3;

  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_CNT  = 3'd1;
  localparam logic [2:0] PTR_SEL  = 3'd2;
  localparam logic [2:0] PTR_INC  = 3'd3;
  localparam logic [2:0] PTR_DEC  = 3'd4;

  localparam logic [1:0] RD_PTR    = 2'd0;
  localparam logic [1:0] RD_PTR_M1 = 2'd1;
  localparam logic [1:0] RD_PTR_P1 = 2'd2;

  localparam int IN_BITS  = 48;
  localparam int OUT_BITS = 48;

  typedef struct packed {
    logic       load;
    logic [1:0] tgt_sel;
    logic       tgt_load;
    logic [2:0] ptr_op;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_value;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [2:0] status;
    logic       emit_data;
    logic       emit_last;
  } isl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       ptr_gt_tgt;
    logic       ptr_next_lt_cnt;
    logic       ptr_last;
    logic       out_free;
  } isl_stat_t;

endpackage

// File: src/isl_ctrl.sv
// Controller state machine sequencing list operations over the datapath.
module isl_ctrl import isl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  isl_stat_t stat,
  output isl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_UP_RD    = 4'd2;
  localparam logic [3:0] S_UP_WR    = 4'd3;
  localparam logic [3:0] S_DN_RD    = 4'd4;
  localparam logic [3:0] S_DN_WR    = 4'd5;
  localparam logic [3:0] S_DUMP_RD  = 4'd6;
  localparam logic [3:0] S_DUMP_OUT = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] st;
  logic [2:0] st_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op) inside
          OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
            if (stat.full) begin
              st_next    = ST_FULL;
              state_next = S_RESP;
            end else begin
              cmd.tgt_load = 1'b1;
              cmd.ptr_op   = PTR_CNT;
              if (stat.op == OP_INS_FRONT) begin
                cmd.tgt_sel = TGT_ZERO;
              end else if (stat.op == OP_INS_POS && !stat.pos_gt_cnt) begin
                cmd.tgt_sel = TGT_POS;
              end else begin
                cmd.tgt_sel = TGT_CNT;
              end
              st_next    = (stat.op == OP_INS_POS && stat.pos_gt_cnt) ? ST_INS_RANGE : ST_OK;
              state_next = S_UP_RD;
            end
          end
          OP_DEL_FRONT, OP_DEL_POS, OP_DEL_END: begin
            if (stat.empty) begin
              st_next    = ST_EMPTY;
              state_next = S_RESP;
            end else if (stat.op == OP_DEL_POS && stat.pos_ge_cnt) begin
              st_next    = ST_DEL_RANGE;
              state_next = S_RESP;
            end else begin
              cmd.ptr_op = PTR_SEL;
              if (stat.op == OP_DEL_FRONT) begin
                cmd.tgt_sel = TGT_ZERO;
              end else if (stat.op == OP_DEL_POS) begin
                cmd.tgt_sel = TGT_POS;
              end else begin
                cmd.tgt_sel = TGT_CNT_M1;
              end
              st_next    = ST_OK;
              state_next = S_DN_RD;
            end
          end
          OP_DUMP: begin
            if (stat.empty) begin
              st_next    = ST_EMPTY;
              state_next = S_RESP;
            end else begin
              cmd.ptr_op  = PTR_SEL;
              cmd.tgt_sel = TGT_ZERO;
              state_next  = S_DUMP_RD;
            end
          end
          default: begin
            st_next    = ST_OK;
            state_next = S_RESP;
          end
        endcase
      end
      S_UP_RD: begin
        if (stat.ptr_gt_tgt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          state_next = S_UP_WR;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.wr_value = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_DEC;
        state_next = S_UP_RD;
      end
      S_DN_RD: begin
        if (stat.ptr_next_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P1;
          state_next = S_DN_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_INC;
        state_next = S_DN_RD;
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.status    = ST_OK;
          cmd.emit_data = 1'b1;
          cmd.emit_last = stat.ptr_last;
          if (stat.ptr_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_op = PTR_INC;
            state_next = S_DUMP_RD;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.status    = st;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/isl_datapath.sv
// Datapath with the element memory, count, pointers and output register.
`include "indexed_sequence_list_defines.svh"
module isl_datapath import isl_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata,
  output logic                m_tlast,
  input  isl_cmd_t            cmd,
  output isl_stat_t           stat
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 6) ? CW : 6;

  logic [VALUE_WIDTH-1:0]        mem [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] rdata;
  logic [2:0]                    op;
  logic [31:0]                   value;
  logic [5:0]                    pos;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 ptr;
  logic [CW-1:0]                 tgt;
  logic [CW-1:0]                 sel_val;
  logic [CW-1:0]                 rd_addr;
  logic [31:0]                   dumped;
  logic                          out_free;

  assign out_free = !m_tvalid || m_tready;
  assign dumped   = 32'(rdata);

  always_comb begin
    case (cmd.tgt_sel)
      TGT_ZERO:   sel_val = '0;
      TGT_POS:    sel_val = CW'(pos);
      TGT_CNT:    sel_val = count;
      default:    sel_val = count - CW'(1);
    endcase
    case (cmd.rd_sel)
      RD_PTR_M1: rd_addr = ptr - CW'(1);
      RD_PTR_P1: rd_addr = ptr + CW'(1);
      default:   rd_addr = ptr;
    endcase
  end

  always_comb begin
    stat.op              = op;
    stat.full            = count >= CW'(CAPACITY);
    stat.empty           = count == '0;
    stat.pos_gt_cnt      = CMPW'(pos) > CMPW'(count);
    stat.pos_ge_cnt      = CMPW'(pos) >= CMPW'(count);
    stat.ptr_gt_tgt      = ptr > tgt;
    stat.ptr_next_lt_cnt = (ptr + CW'(1)) < count;
    stat.ptr_last        = (ptr + CW'(1)) == count;
    stat.out_free        = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr[AW-1:0]] <= cmd.wr_value ? VALUE_WIDTH'(value) : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= s_tdata[2:0];
      value <= s_tdata[34:3];
      pos   <= s_tdata[40:35];
    end
    if (cmd.tgt_load) begin
      tgt <= sel_val;
    end
    case (cmd.ptr_op)
      PTR_CNT: ptr <= count;
      PTR_SEL: ptr <= sel_val;
      PTR_INC: ptr <= ptr + CW'(1);
      PTR_DEC: ptr <= ptr - CW'(1);
      default: ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {7'd0, 6'(count), (cmd.emit_data ? dumped : 32'd0), cmd.status};
      m_tlast <= cmd.emit_last;
    end
  end

  `ISL_ASSERT_SAME(a_inc_not_full, cmd.cnt_inc, !stat.full, "insert into full list")
  `ISL_ASSERT_SAME(a_dec_not_empty, cmd.cnt_dec, !stat.empty, "delete from empty list")
  `ISL_ASSERT_SAME(a_emit_free, cmd.emit, out_free, "pending result overwritten")
  `ISL_ASSERT_NEXT(a_inc_grows, cmd.cnt_inc, count == $past(count) + CW'(1), "count did not grow")

endmodule

// File: src/indexed_sequence_list.sv
// Indexed sequence list: a bounded ordered list of signed values, top level.
//
// Input channel s_t*: one transaction carries an opcode (insert front, at a
// position or at the end; delete front, at a position or at the end; dump),
// a value and a position. Output channel m_t*: result transactions carry a
// status, a dumped value and the list length after the operation; m_tlast
// marks the final result of each input transaction.
// Inserts and deletes return one result; a dump returns one result per stored
// element, or a single empty status for an empty list.
// An insert or a delete passes S_EXEC, then a read state and a write state
// for each entry that it moves, then S_RESP, which loads the output
// register. A dump reads each element in S_DUMP_RD and loads it into the
// output register in S_DUMP_OUT. The element memory is never read and
// written in the same state.
// One input transaction is worked at a time; s_tready returns high once its
// last result sits in the output register, so the next one can start while
// that result waits.
// Reset empties the list and drops any pending result; memory contents are
// not cleared. When the receiver stalls, the result is held in the output
// register and the sequencer waits before producing the next one.
module indexed_sequence_list import isl_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // Fields from bit 0: opcode[2:0], element_value[34:3], position[40:35].
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // Fields from bit 0: status[2:0], dumped_value[34:3], list_length[40:35].
  output logic [OUT_BITS-1:0] m_tdata,
  output logic                m_tlast
);

  isl_cmd_t  cmd;
  isl_stat_t stat;

  isl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  isl_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
